// ===== rtl/fat12cc_pkg.sv =====
`timescale 1ns / 1ps
// fat12cc_pkg: shared constants and types for the fat12 cluster chain follower
// no dependencies; imported by the top level, its port checker and the bench

package fat12cc_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;

    // item field widths
    localparam int ACTION_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int CLUSTER_W = 12;
    localparam int DSS_W     = 24;
    localparam int SPC_W     = 8;
    localparam int SECTOR_W  = 25;
    localparam int PROD_W    = CLUSTER_W + SPC_W;

    // packed port widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // end-of-chain marker and nibble masks
    localparam logic [CLUSTER_W-1:0] EOC_MARK  = 12'hFF8;
    localparam logic [BYTE_W-1:0]    LO_NIBBLE = 8'h0F;
    localparam logic [BYTE_W-1:0]    HI_NIBBLE = 8'hF0;

    // configuration register indexes
    localparam logic REG_BASE_SECTOR = 1'b0;
    localparam logic REG_SPC         = 1'b1;

    // item kinds carried on s_tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_LOOKUP  = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    // position within a three-byte group
    typedef enum logic [1:0] {
        PH_LOW  = 2'd0,
        PH_MID  = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

endpackage

// ===== rtl/fat12_cluster_chain_follower_top.sv =====
`timescale 1ns / 1ps
// fat12_cluster_chain_follower_top: fat12 table loader and cluster lookup
// depends on fat12cc_pkg

// The block takes one item per clock on the slave stream while s_tready is
// high. A load item feeds one packed table byte; every three bytes unpack into
// two 12-bit entries written into an on-chip 4096 x 12 table memory, and bytes
// past the end of the table are dropped. A restart item rewinds loading to
// entry 0 (old entries stay in memory but read as beyond the table until
// reloaded). A lookup item reads the entry of the given cluster and returns
// next cluster, start sector (base sector register + (cluster - 2) * cluster
// size in sectors) and the end-of-chain and bad-cluster flags; clusters below 2
// or not yet loaded give bad_cluster with all other fields zero. Load, restart
// and unused items give no result. Throughput is one item per cycle while
// s_tready is high; a lookup result passes through the registered read of the
// table memory in the read stage and then through the output register.
// s_tready drops only while a lookup sits in the read stage and the output
// register holds a result that is not being taken. No clearing pass runs after
// reset. Configuration writes are expected only while no lookup is in flight.

module fat12_cluster_chain_follower_top
    import fat12cc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [DSS_W-1:0]     cfg_data,
    // slave stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // table_byte[7:0], cluster_number[19:8], zero pad
    input  logic [ACTION_W-1:0]  s_tuser,   // action[1:0]
    // master stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // next_cluster[11:0], start_sector[36:12], zero pad
    output logic [M_TUSER_W-1:0] m_tuser    // end_of_chain[0], bad_cluster[1]
);

    // configuration registers
    logic [DSS_W-1:0] dss_reg;
    logic [SPC_W-1:0] spc_reg;

    // loader state
    logic [CNT_W-1:0]  widx_reg, widx_next;
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] low_reg, low_next;
    logic [3:0]        nibble_reg, nibble_next;

    // table memory
    logic [CLUSTER_W-1:0] entry_mem [TABLE_ENTRIES];
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [CLUSTER_W-1:0] mem_wdata;
    logic                 mem_re;
    logic [CLUSTER_W-1:0] rd_data_reg;

    // read stage
    logic              s1_valid_reg;
    logic              s1_bad_reg;
    logic [PROD_W-1:0] s1_prod_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [CLUSTER_W-1:0] out_next_reg;
    logic [SECTOR_W-1:0]  out_sector_reg;
    logic                 out_eoc_reg;
    logic                 out_bad_reg;

    // input item fields
    action_t              action;
    logic [BYTE_W-1:0]    tbyte;
    logic [CLUSTER_W-1:0] cluster;
    assign action  = action_t'(s_tuser);
    assign tbyte   = s_tdata[BYTE_W-1:0];
    assign cluster = s_tdata[BYTE_W +: CLUSTER_W];

    // handshake: the read stage moves on whenever the output register is free
    logic out_free;
    logic s1_move;
    logic accept;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // lookup range check against the entries loaded so far
    logic [CLUSTER_W:0]   widx_ext;
    logic                 lookup_bad;
    logic [CLUSTER_W-1:0] cluster_m2;
    logic [PROD_W-1:0]    prod_next;
    assign widx_ext   = (CLUSTER_W + 1)'(widx_reg);
    assign lookup_bad = (cluster < CLUSTER_W'(2)) || ({1'b0, cluster} >= widx_ext);
    assign cluster_m2 = cluster - CLUSTER_W'(2);
    assign prod_next  = PROD_W'(cluster_m2) * PROD_W'(spc_reg);

    assign mem_re    = accept && (action == ACT_LOOKUP) && !lookup_bad;
    assign mem_waddr = widx_reg[IDX_W-1:0];

    // byte unpacking: low byte held, then two entries per three bytes
    always_comb
    begin
        widx_next   = widx_reg;
        phase_next  = phase_reg;
        low_next    = low_reg;
        nibble_next = nibble_reg;
        mem_we      = 1'b0;
        mem_wdata   = '0;
        if (accept)
        begin
            case (action)
                ACT_LOAD:
                begin
                    // table full: byte is dropped
                    if (widx_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        case (phase_reg)
                            PH_LOW:
                            begin
                                low_next   = tbyte;
                                phase_next = PH_MID;
                            end
                            PH_MID:
                            begin
                                mem_we      = 1'b1;
                                mem_wdata   = {tbyte[3:0], low_reg};
                                nibble_next = 4'((tbyte & HI_NIBBLE) >> 4);
                                widx_next   = widx_reg + CNT_W'(1);
                                phase_next  = PH_HIGH;
                            end
                            PH_HIGH:
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = {tbyte, nibble_reg};
                                widx_next  = widx_reg + CNT_W'(1);
                                phase_next = PH_LOW;
                            end
                            default:
                            begin
                                phase_next = PH_LOW;
                            end
                        endcase
                    end
                end
                ACT_RESTART:
                begin
                    widx_next   = '0;
                    phase_next  = PH_LOW;
                    low_next    = '0;
                    nibble_next = '0;
                end
                default:
                begin
                    // lookups and the unused code leave the loader alone
                end
            endcase
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dss_reg      <= '0;
            spc_reg      <= SPC_W'(1);
            widx_reg     <= '0;
            phase_reg    <= PH_LOW;
            low_reg      <= '0;
            nibble_reg   <= '0;
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_SECTOR: dss_reg <= cfg_data;
                    REG_SPC:         spc_reg <= cfg_data[SPC_W-1:0];
                    default:         ;
                endcase
            end
            widx_reg   <= widx_next;
            phase_reg  <= phase_next;
            low_reg    <= low_next;
            nibble_reg <= nibble_next;

            if (accept && (action == ACT_LOOKUP))
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= entry_mem[cluster[IDX_W-1:0]];
    end

    // read stage payload, held while the stage stalls
    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_LOOKUP))
        begin
            s1_bad_reg  <= lookup_bad;
            s1_prod_reg <= prod_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            if (s1_bad_reg)
            begin
                out_next_reg   <= '0;
                out_sector_reg <= '0;
                out_eoc_reg    <= 1'b0;
                out_bad_reg    <= 1'b1;
            end
            else
            begin
                out_next_reg   <= rd_data_reg;
                out_sector_reg <= SECTOR_W'(dss_reg) + SECTOR_W'(s1_prod_reg);
                out_eoc_reg    <= (rd_data_reg >= EOC_MARK);
                out_bad_reg    <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_sector_reg, out_next_reg});
    assign m_tuser  = {out_bad_reg, out_eoc_reg};

endmodule

// ===== rtl/fat12cc_checker.sv =====
`timescale 1ns / 1ps
// fat12cc_checker: port-level checks on the result stream of the top level
// depends on fat12cc_pkg; bound to fat12_cluster_chain_follower_top

module fat12cc_checker
    import fat12cc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tready,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

    // a bad cluster carries no entry and no sector
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
    else $error("bad cluster with nonzero payload");

    // end of chain agrees with the returned entry
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> (m_tuser[0] == (m_tdata[CLUSTER_W-1:0] >= EOC_MARK)))
    else $error("end of chain flag disagrees with next cluster");

    // input is refused only while a result waits untaken
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with free output");

endmodule

bind fat12_cluster_chain_follower_top fat12cc_checker u_fat12cc_checker (.*);

// ===== bench/tb_fat12_check_pkg.sv =====
`timescale 1ns / 1ps
// fat12_check_pkg: lookup result type and chain scoreboard for the bench
// depends on fat12cc_pkg for widths, action codes and register indexes

package fat12_check_pkg;
    import fat12cc_pkg::*;

    // action code the block ignores
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [CLUSTER_W-1:0] next_cluster;
        logic [SECTOR_W-1:0]  start_sector;
        logic                 end_of_chain;
        logic                 bad_cluster;
    } lookup_result_t;

    class chain_scoreboard;
        logic [CLUSTER_W-1:0] fat_copy [TABLE_ENTRIES];
        int unsigned          entries_loaded;
        phase_t               group_pos;
        logic [BYTE_W-1:0]    low_byte;
        logic [3:0]           high_nibble;
        logic [DSS_W-1:0]     base_sector;
        logic [SPC_W-1:0]     spc;
        lookup_result_t       awaited_lookups [$];
        int unsigned          mismatches;
        int unsigned          items_seen;
        int unsigned          lookups_checked;
        int unsigned          bad_seen;
        int unsigned          eoc_seen;
        int unsigned          bytes_dropped;

        function new();
            entries_loaded  = 0;
            group_pos       = PH_LOW;
            low_byte        = '0;
            high_nibble     = '0;
            base_sector     = '0;
            spc             = 8'd1;
            mismatches      = 0;
            items_seen      = 0;
            lookups_checked = 0;
            bad_seen        = 0;
            eoc_seen        = 0;
            bytes_dropped   = 0;
        endfunction

        function void write_reg(logic idx, logic [DSS_W-1:0] value);
            if (idx == REG_BASE_SECTOR)
                base_sector = value;
            else
                spc = value[SPC_W-1:0];
        endfunction

        function int unsigned outstanding();
            return awaited_lookups.size();
        endfunction

        function void push_entry(logic [CLUSTER_W-1:0] value);
            if (entries_loaded < TABLE_ENTRIES)
            begin
                fat_copy[entries_loaded] = value;
                entries_loaded++;
            end
        endfunction

        // three packed bytes unpack into two 12-bit entries
        function void take_byte(logic [BYTE_W-1:0] b);
            if (entries_loaded >= TABLE_ENTRIES)
            begin
                bytes_dropped++;
                return;
            end
            case (group_pos)
                PH_LOW:
                begin
                    low_byte  = b;
                    group_pos = PH_MID;
                end
                PH_MID:
                begin
                    push_entry({b[3:0], low_byte});
                    high_nibble = b[7:4];
                    group_pos   = PH_HIGH;
                end
                default:
                begin
                    push_entry({b, high_nibble});
                    group_pos = PH_LOW;
                end
            endcase
        endfunction

        function void note_item(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b,
                                logic [CLUSTER_W-1:0] cl);
            lookup_result_t r;
            int unsigned    sector;
            items_seen++;
            if (act == ACT_LOAD)
                take_byte(b);
            else if (act == ACT_RESTART)
            begin
                entries_loaded = 0;
                group_pos      = PH_LOW;
                low_byte       = '0;
                high_nibble    = '0;
            end
            else if (act == ACT_LOOKUP)
            begin
                r = '0;
                if (cl < 2 || cl >= entries_loaded)
                    r.bad_cluster = 1'b1;
                else
                begin
                    sector = int'(base_sector) + (int'(cl) - 2) * int'(spc);
                    r.next_cluster = fat_copy[cl];
                    r.start_sector = sector[SECTOR_W-1:0];
                    r.end_of_chain = (fat_copy[cl] >= EOC_MARK);
                end
                awaited_lookups.push_back(r);
            end
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (awaited_lookups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: result with no lookup waiting: ",
                             "next %03h sector %07h eoc %b bad %b",
                             got.next_cluster, got.start_sector, got.end_of_chain,
                             got.bad_cluster);
                return;
            end
            want = awaited_lookups.pop_front();
            lookups_checked++;
            if (want.bad_cluster)
                bad_seen++;
            if (want.end_of_chain)
                eoc_seen++;
            if (got.next_cluster !== want.next_cluster || got.start_sector !== want.start_sector
                || got.end_of_chain !== want.end_of_chain || got.bad_cluster !== want.bad_cluster)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: lookup %0d expected next %03h sector %07h eoc %b bad %b,",
                             lookups_checked, want.next_cluster, want.start_sector,
                             want.end_of_chain, want.bad_cluster,
                             " got next %03h sector %07h eoc %b bad %b", got.next_cluster,
                             got.start_sector, got.end_of_chain, got.bad_cluster);
            end
        endfunction
    endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stream bench for the fat12 cluster chain follower
// depends on fat12cc_pkg, fat12_check_pkg and the top level of the block

module tb_top;
    import fat12cc_pkg::*;
    import fat12_check_pkg::*;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [DSS_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // table_byte[7:0], cluster_number[19:8], zero pad
    logic [ACTION_W-1:0]  s_tuser   = '0;   // action[1:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // next_cluster[11:0], start_sector[36:12], zero pad
    logic [M_TUSER_W-1:0] m_tuser;          // end_of_chain[0], bad_cluster[1]

    // idle odds per cycle, in percent, and the length of a forced receiver hold-off
    int unsigned     src_idle_pct  = 0;
    int unsigned     sink_idle_pct = 0;
    int unsigned     hold_left     = 0;
    chain_scoreboard sb = new();

    fat12_cluster_chain_follower_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // receiver: random back-pressure, or a long hold-off when one is requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // both handshakes are sampled at the edge, before any nonblocking update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata[7:0], s_tdata[19:8]);
            if (m_tvalid && m_tready)
                sb.check_result({m_tdata[11:0], m_tdata[36:12], m_tuser[0], m_tuser[1]});
        end
    end

    // offer one item after a random gap and hold it until it is taken;
    // the field the action does not use carries random noise from the callers
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
                             input logic [CLUSTER_W-1:0] cl);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0000, cl, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic load_byte(input logic [BYTE_W-1:0] b);
        send_item(ACT_LOAD, b, CLUSTER_W'($urandom_range(0, 4095)));
    endtask

    task automatic lookup(input logic [CLUSTER_W-1:0] cl);
        send_item(ACT_LOOKUP, BYTE_W'($urandom_range(0, 255)), cl);
    endtask

    task automatic restart_table();
        send_item(ACT_RESTART, BYTE_W'($urandom_range(0, 255)),
                  CLUSTER_W'($urandom_range(0, 4095)));
    endtask

    // stop offering, let every lookup come back, then let any load and restart
    // items still in the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DSS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // restart and load a fresh table of 64 random entries
    task automatic fill_table();
        restart_table();
        repeat (96) load_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // random mix: byte runs, lookups mostly within or just past the loaded part,
    // occasional restarts and unused actions; ignored items are not counted
    task automatic run_random(input int unsigned count, input int unsigned restart_pct,
                              input int unsigned wide_pct);
        int unsigned sent;
        int unsigned pick;
        int unsigned burst;
        int unsigned top;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < restart_pct)
            begin
                restart_table();
                sent++;
            end
            else if (pick < restart_pct + 3)
                send_item(ACT_UNUSED, BYTE_W'($urandom_range(0, 255)),
                          CLUSTER_W'($urandom_range(0, 4095)));
            else if (pick < 50)
            begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                begin
                    if (sb.entries_loaded < TABLE_ENTRIES)
                        sent++;
                    load_byte(BYTE_W'($urandom_range(0, 255)));
                end
            end
            else
            begin
                if ($urandom_range(0, 99) < wide_pct || sb.entries_loaded >= 4094)
                    top = 4095;
                else
                    top = sb.entries_loaded + 1;
                lookup(CLUSTER_W'($urandom_range(0, top)));
                sent++;
            end
        end
    endtask

    initial
    begin
        // phase one: sender idles a little, receiver a lot
        src_idle_pct  = 18;
        sink_idle_pct = 69;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, reserved clusters, the last cluster number
        lookup(12'd0);
        lookup(12'd1);
        lookup(12'd2);
        lookup(12'd4095);
        // entries 0 0, ff7 ff8 (chain end boundary), fff fff, then a stray byte
        load_byte(8'h00);
        load_byte(8'h00);
        load_byte(8'h00);
        load_byte(8'hF7);
        load_byte(8'h8F);
        load_byte(8'hFF);
        load_byte(8'hFF);
        load_byte(8'hFF);
        load_byte(8'hFF);
        load_byte(8'hA5);
        lookup(12'd2);
        lookup(12'd3);
        lookup(12'd4);
        lookup(12'd5);
        lookup(12'd6);
        lookup(12'd1);
        lookup(12'd0);
        // unused action, then a restart hides what was loaded
        send_item(ACT_UNUSED, 8'hFF, 12'hFFF);
        restart_table();
        lookup(12'd2);

        run_random(180, 4, 10);

        // phase two: largest base sector, largest legal cluster size, fresh table
        wait_idle();
        write_reg(REG_BASE_SECTOR, 24'hFFFFFF);
        write_reg(REG_SPC, 24'd128);
        src_idle_pct  = 69;
        sink_idle_pct = 18;
        fill_table();
        lookup(12'd4095);
        lookup(12'd4094);
        lookup(12'd2);
        lookup(12'd1);
        run_random(180, 0, 100);
        // restart over a loaded table: stale entries stay unreachable until reloaded
        restart_table();
        lookup(12'd100);
        load_byte(BYTE_W'($urandom_range(0, 255)));
        load_byte(BYTE_W'($urandom_range(0, 255)));
        load_byte(BYTE_W'($urandom_range(0, 255)));
        lookup(12'd2);
        lookup(12'd3);

        // phase three: no idling, zero cluster size, then a long receiver hold-off
        wait_idle();
        write_reg(REG_BASE_SECTOR, DSS_W'($urandom_range(0, 24'hFFFFFF)));
        write_reg(REG_SPC, 24'd0);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(100, 3, 10);
        hold_left = 400;
        repeat (60) lookup(CLUSTER_W'($urandom_range(0, sb.entries_loaded + 1)));

        // large sector reach: out-of-range cluster size over a fresh table
        wait_idle();
        write_reg(REG_BASE_SECTOR, 24'hFFFFFF);
        write_reg(REG_SPC, 24'd255);
        fill_table();
        run_random(100, 0, 100);

        wait_idle();
        $display("summary: %0d items accepted, %0d lookups checked",
                 sb.items_seen, sb.lookups_checked,
                 " (%0d bad clusters, %0d chain ends)", sb.bad_seen, sb.eoc_seen);
        $display("summary: %0d table bytes dropped on a full table, %0d mismatches",
                 sb.bytes_dropped, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
